FILE: rtl/pcsf_pkg.sv
// ----------------------------------------------------------------------------
// pcsf_pkg - shared types and constants for the phase current sense filter
// Field widths, register indexes, reset values and the lane control word.
// ----------------------------------------------------------------------------
package pcsf_pkg;

    localparam int ADC_BITS        = 12;
    localparam int CAL_SAMPLES_DEF = 200;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 1;
    localparam int FILT_W          = 32;
    localparam int FRAC_W          = 16;
    localparam int SCALE_SH        = 8;
    localparam int MA_W            = 16;
    localparam int PHC_W           = 18;
    localparam int S_TDATA_W       = 24;
    localparam int M_TDATA_W       = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_LSB_SCALE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA = 1'b1;

    localparam logic [CFG_W-1:0] LSB_SCALE_RESET    = 16'd2063;
    localparam logic [CFG_W-1:0] FILTER_ALPHA_RESET = 16'd328;

    localparam logic [ADC_BITS-1:0] OFFSET_RESET = {1'b1, {(ADC_BITS-1){1'b0}}};

    localparam logic OP_MEASURE   = 1'b0;
    localparam logic OP_CALIBRATE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_A,
        ST_UPDATE,
        ST_ROUND,
        ST_OUTPUT
    } pcsf_state_t;

    typedef struct packed {
        logic capture;
        logic mul_x;
        logic mul_a;
        logic update;
        logic round_en;
        logic cal;
        logic cal_last;
    } lane_ctrl_t;

endpackage

FILE: rtl/pcsf_lane.sv
// ----------------------------------------------------------------------------
// pcsf_lane - one phase of the current sense path
// Offset calibration (sum and divide by constant), gain scaling, Q16.16
// exponential moving average and rounding to saturated milliamps.
// ----------------------------------------------------------------------------
module pcsf_lane #(
    parameter int CAL_SAMPLES = pcsf_pkg::CAL_SAMPLES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  pcsf_pkg::lane_ctrl_t               ctrl,
    input  logic [pcsf_pkg::ADC_BITS-1:0]      sample,
    input  logic [pcsf_pkg::CFG_W-1:0]         lsb_scale,
    input  logic [pcsf_pkg::CFG_W-1:0]         filter_alpha,
    output logic signed [pcsf_pkg::MA_W-1:0]   ma
);
    import pcsf_pkg::*;

    localparam int    CNT_L   = $clog2(CAL_SAMPLES);
    localparam int    SUM_W   = ADC_BITS + CNT_L;
    localparam int    MUL_W   = SUM_W + 2;
    localparam int    DIV_SH  = SUM_W + CNT_L;
    localparam longint DIV_MUL =
        ((longint'(1) << DIV_SH) + longint'(CAL_SAMPLES) - 1) / longint'(CAL_SAMPLES);
    localparam int    DIFF_W  = ADC_BITS + 1;
    localparam int    XP_W    = DIFF_W + CFG_W;
    localparam int    KEEP_W  = FILT_W - SCALE_SH;
    localparam int    WP_W    = FILT_W + CFG_W + 2;

    logic [ADC_BITS-1:0]        sample_reg;
    logic [ADC_BITS-1:0]        offset_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [SUM_W+MUL_W-1:0]     divp_reg;
    logic signed [XP_W-1:0]     xprod_reg;
    logic signed [WP_W-1:0]     wprod_reg;
    logic signed [FILT_W-1:0]   filt_reg;
    logic signed [MA_W-1:0]     ma_reg;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [XP_W-1:0]     xprod_next;
    logic [XP_W-KEEP_W:0]       x_hi;
    logic signed [FILT_W-1:0]   x_sat;
    logic signed [FILT_W:0]     err;
    logic signed [WP_W-1:0]     wprod_next;
    logic [MUL_W-1:0]           div_mul;
    logic signed [FILT_W:0]     rnd;
    logic signed [MA_W-1:0]     ma_next;

    always_comb begin
        diff       = $signed({1'b0, offset_reg}) - $signed({1'b0, sample_reg});
        xprod_next = diff * $signed({1'b0, lsb_scale});
        x_hi       = xprod_reg[XP_W-1:KEEP_W-1];
        if ((&x_hi) || !(|x_hi)) begin
            x_sat = {xprod_reg[KEEP_W-1:0], {SCALE_SH{1'b0}}};
        end else if (xprod_reg[XP_W-1]) begin
            x_sat = {1'b1, {(FILT_W-1){1'b0}}};
        end else begin
            x_sat = {1'b0, {(FILT_W-1){1'b1}}};
        end
        err        = {x_sat[FILT_W-1], x_sat} - {filt_reg[FILT_W-1], filt_reg};
        wprod_next = err * $signed({1'b0, filter_alpha});
        div_mul    = MUL_W'(DIV_MUL);
        rnd        = {filt_reg[FILT_W-1], filt_reg}
                     + $signed({{(FILT_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}});
        if (rnd[FILT_W] != rnd[FILT_W-1]) begin
            ma_next = rnd[FILT_W] ? {1'b1, {(MA_W-1){1'b0}}} : {1'b0, {(MA_W-1){1'b1}}};
        end else begin
            ma_next = rnd[FRAC_W +: MA_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= OFFSET_RESET;
            sum_reg    <= '0;
            filt_reg   <= '0;
        end else begin
            if (ctrl.mul_x && ctrl.cal) begin
                sum_reg <= sum_reg + SUM_W'(sample_reg);
            end
            if (ctrl.update && ctrl.cal && ctrl.cal_last) begin
                offset_reg <= divp_reg[DIV_SH +: ADC_BITS];
                sum_reg    <= '0;
            end
            if (ctrl.update && !ctrl.cal) begin
                filt_reg <= filt_reg + wprod_reg[FRAC_W +: FILT_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            sample_reg <= sample;
        end
        if (ctrl.mul_x && !ctrl.cal) begin
            xprod_reg <= xprod_next;
        end
        if (ctrl.mul_a && !ctrl.cal) begin
            wprod_reg <= wprod_next;
        end
        if (ctrl.mul_a && ctrl.cal && ctrl.cal_last) begin
            divp_reg <= sum_reg * div_mul;
        end
        if (ctrl.round_en) begin
            ma_reg <= ma_next;
        end
    end

    assign ma = ma_reg;

endmodule

FILE: rtl/pcsf_merge.sv
// ----------------------------------------------------------------------------
// pcsf_merge - combine the phase lanes into one result word
// Derives phase C from A and B and holds the word in the output register.
// ----------------------------------------------------------------------------
module pcsf_merge (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  logic signed [pcsf_pkg::MA_W-1:0]    ma_a,
    input  logic signed [pcsf_pkg::MA_W-1:0]    ma_b,
    input  logic                                cal_done,
    output logic                                free,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pcsf_pkg::M_TDATA_W-1:0]      m_tdata,   // current_a, current_b, current_c
    output logic                                m_tuser    // cal_done
);
    import pcsf_pkg::*;

    logic                       valid_reg;
    logic [M_TDATA_W-1:0]       data_reg;
    logic                       user_reg;
    logic signed [PHC_W-1:0]    phc;

    always_comb begin
        phc = -$signed({{(PHC_W-MA_W){ma_a[MA_W-1]}}, ma_a})
              - $signed({{(PHC_W-MA_W){ma_b[MA_W-1]}}, ma_b});
    end

    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {{(M_TDATA_W-PHC_W-2*MA_W){1'b0}}, phc, ma_b, ma_a};
            user_reg <= cal_done;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

FILE: rtl/phase_current_sense_filter.sv
// ----------------------------------------------------------------------------
// phase_current_sense_filter - shunt offset calibration and current filter
// A taken word runs through the five-step lane sequencer (two registered
// multiplies, filter update, rounding, output load); a new word is taken
// only in idle, and the output load waits until the output register is free.
// Reset: synchronous, active low; offsets to mid scale, filters, sums and
// calibration count to zero, registers to their defaults.
// ----------------------------------------------------------------------------
module phase_current_sense_filter #(
    parameter int CAL_SAMPLES = pcsf_pkg::CAL_SAMPLES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [pcsf_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [pcsf_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pcsf_pkg::S_TDATA_W-1:0]      s_tdata,   // sample_a, sample_b
    input  logic                                s_tuser,   // opcode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pcsf_pkg::M_TDATA_W-1:0]      m_tdata,   // current_a, current_b, current_c
    output logic                                m_tuser    // cal_done
);
    import pcsf_pkg::*;

    localparam int CNT_W = $clog2(CAL_SAMPLES);

    pcsf_state_t            state_reg, state_next;
    logic [CFG_W-1:0]       lsb_scale_reg;
    logic [CFG_W-1:0]       filter_alpha_reg;
    logic                   op_reg;
    logic [CNT_W-1:0]       cal_count_reg;
    logic                   done_reg;
    logic                   take;
    logic                   load;
    logic                   free;
    lane_ctrl_t             ctrl;
    logic signed [MA_W-1:0] ma_a;
    logic signed [MA_W-1:0] ma_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lsb_scale_reg    <= LSB_SCALE_RESET;
            filter_alpha_reg <= FILTER_ALPHA_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_LSB_SCALE:    lsb_scale_reg    <= cfg_wdata;
                CFG_FILTER_ALPHA: filter_alpha_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:  state_next = ST_MUL_A;
            ST_MUL_A:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_OUTPUT;
            ST_OUTPUT: begin
                if (free) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    assign take = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_count_reg <= '0;
            done_reg      <= 1'b0;
            op_reg        <= OP_MEASURE;
        end else begin
            if (take) begin
                op_reg   <= s_tuser;
                done_reg <= 1'b0;
            end
            if (state_reg == ST_MUL_X && op_reg == OP_CALIBRATE) begin
                if (cal_count_reg == CNT_W'(CAL_SAMPLES - 1)) begin
                    cal_count_reg <= '0;
                    done_reg      <= 1'b1;
                end else begin
                    cal_count_reg <= cal_count_reg + 1'b1;
                end
            end
        end
    end

    always_comb begin
        ctrl.capture  = take;
        ctrl.mul_x    = (state_reg == ST_MUL_X);
        ctrl.mul_a    = (state_reg == ST_MUL_A);
        ctrl.update   = (state_reg == ST_UPDATE);
        ctrl.round_en = (state_reg == ST_ROUND);
        ctrl.cal      = (op_reg == OP_CALIBRATE);
        ctrl.cal_last = done_reg;
    end

    pcsf_lane #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_lane_a (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .sample       (s_tdata[ADC_BITS-1:0]),
        .lsb_scale    (lsb_scale_reg),
        .filter_alpha (filter_alpha_reg),
        .ma           (ma_a)
    );

    pcsf_lane #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_lane_b (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .sample       (s_tdata[2*ADC_BITS-1:ADC_BITS]),
        .lsb_scale    (lsb_scale_reg),
        .filter_alpha (filter_alpha_reg),
        .ma           (ma_b)
    );

    pcsf_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .ma_a     (ma_a),
        .ma_b     (ma_b),
        .cal_done (done_reg),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
